// File: hw/rtl/npc_pkg.sv
`timescale 1ns / 1ps
package npc_pkg;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 10;
  localparam int DIST_W = 34;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

endpackage

// File: hw/rtl/npc_ram.sv
`timescale 1ns / 1ps
module npc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/npc_dist.sv
`timescale 1ns / 1ps
module npc_dist
  import npc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int TAG_W       = 58
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [3*COORD_WIDTH-1:0]   model_pt,
  input  logic [3*COORD_WIDTH-1:0]   query_pt,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_vld,
  output logic [DIST_W-1:0]          out_dist,
  output logic [TAG_W-1:0]           out_tag,
  output logic                       busy
);

  localparam int W   = COORD_WIDTH;
  localparam int SQW = 2 * W;
  localparam int EW  = (SQW > DIST_W) ? SQW : DIST_W;
  localparam int SW  = DIST_W + 1;

  logic [3:0] vld_r;
  logic [TAG_W-1:0] tag1_r, tag2_r, tag3_r, tag4_r;
  logic [W-1:0] mag_r [3];
  logic [W-1:0] mag_nxt [3];
  logic [DIST_W-1:0] sq_r [3];
  logic [DIST_W-1:0] sq_nxt [3];
  logic [DIST_W-1:0] ab_r, ab_nxt, c_r, sum_r, sum_nxt;
  logic [SW-1:0] ab_full, abc_full;

  always_comb begin
    logic signed [W:0] d;
    logic [EW-1:0] me;
    logic [EW-1:0] sq;
    for (int k = 0; k < 3; k++) begin
      d = (W+1)'($signed(model_pt[k*W +: W])) - (W+1)'($signed(query_pt[k*W +: W]));
      mag_nxt[k] = d[W] ? W'(-d) : W'(d);
      me = EW'(mag_r[k]);
      sq = me * me;
      sq_nxt[k] = (sq > EW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq);
    end
  end

  assign ab_full  = SW'(sq_r[0]) + SW'(sq_r[1]);
  assign ab_nxt   = ab_full[DIST_W] ? DIST_MAX : ab_full[DIST_W-1:0];
  assign abc_full = SW'(ab_r) + SW'(c_r);
  assign sum_nxt  = abc_full[DIST_W] ? DIST_MAX : abc_full[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
    for (int k = 0; k < 3; k++) begin
      mag_r[k] <= mag_nxt[k];
      sq_r[k]  <= sq_nxt[k];
    end
    tag1_r <= in_tag;
    tag2_r <= tag1_r;
    ab_r   <= ab_nxt;
    c_r    <= sq_r[2];
    tag3_r <= tag2_r;
    sum_r  <= sum_nxt;
    tag4_r <= tag3_r;
  end

  assign out_vld  = vld_r[3];
  assign out_dist = sum_r;
  assign out_tag  = tag4_r;
  assign busy     = |vld_r;

endmodule

// File: hw/rtl/nearest_point_correspondence.sv
`timescale 1ns / 1ps
// A load or clear request completes as it is accepted; the block stays idle.
// A query reads one stored point per cycle from the point RAM.
// A result waits in the output register while the next request is accepted.
// Reset empties the store (count cleared); point RAM contents stay undefined.
module nearest_point_correspondence
  import npc_pkg::*;
#(
  parameter int MODEL_DEPTH = 1024,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [FUNC_W-1:0]             in_func,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic signed [COORD_WIDTH-1:0] out_match_x,
  output logic signed [COORD_WIDTH-1:0] out_match_y,
  output logic signed [COORD_WIDTH-1:0] out_match_z,
  output logic [IDX_W-1:0]              out_match_index,
  output logic [DIST_W-1:0]             out_match_distance_sq
);

  localparam int W     = COORD_WIDTH;
  localparam int PW    = 3 * W;
  localparam int AW    = $clog2(MODEL_DEPTH);
  localparam int CW    = $clog2(MODEL_DEPTH + 1);
  localparam int TAG_W = AW + PW;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] rd_idx_r;
  logic rd_vld_r;
  logic [PW-1:0] query_r;

  logic ram_we;
  logic [PW-1:0] ram_rdata;

  logic dv, dbusy;
  logic [DIST_W-1:0] dd;
  logic [TAG_W-1:0] dtag;

  logic found_r;
  logic [DIST_W-1:0] best_d_r;
  logic [TAG_W-1:0] best_tag_r;
  logic upd;

  logic out_valid_r, out_found_r;
  logic [TAG_W-1:0] out_tag_r;
  logic [DIST_W-1:0] out_dist_r;

  logic in_fire, is_query, is_full, last_rd, drain_done;

  assign in_ready   = state_r == ST_IDLE;
  assign in_fire    = in_valid && in_ready;
  assign is_query   = in_fire && (in_func == FUNC_QUERY);
  assign is_full    = count_r == CW'(MODEL_DEPTH);
  assign ram_we     = in_fire && (in_func == FUNC_LOAD) && !is_full;
  assign last_rd    = (CW'({1'b0, rd_ptr_r}) + CW'(1)) == count_r;
  assign drain_done = (state_r == ST_DRAIN) && !rd_vld_r && !dbusy
                      && (!out_valid_r || out_ready);

  npc_ram #(
    .WIDTH(PW),
    .DEPTH(MODEL_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata({in_point_x, in_point_y, in_point_z}),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  npc_dist #(
    .COORD_WIDTH(W),
    .TAG_W      (TAG_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .model_pt(ram_rdata),
    .query_pt(query_r),
    .in_tag  ({rd_idx_r, ram_rdata}),
    .out_vld (dv),
    .out_dist(dd),
    .out_tag (dtag),
    .busy    (dbusy)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_func)
            FUNC_LOAD: begin
              if (!is_full) begin
                count_nxt = count_r + CW'(1);
              end
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            FUNC_QUERY: begin
              rd_ptr_nxt = '0;
              state_nxt  = (count_r == '0) ? ST_DRAIN : ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_ptr_nxt = rd_ptr_r + AW'(1);
        if (last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign upd = dv && (!found_r || (dd < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= state_r == ST_SCAN;
      if (is_query) begin
        found_r <= 1'b0;
      end else if (upd) begin
        found_r <= 1'b1;
      end
      if (drain_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    rd_ptr_r <= rd_ptr_nxt;
    rd_idx_r <= rd_ptr_r;
    if (is_query) begin
      query_r    <= {in_point_x, in_point_y, in_point_z};
      best_d_r   <= '0;
      best_tag_r <= '0;
    end else if (upd) begin
      best_d_r   <= dd;
      best_tag_r <= dtag;
    end
    if (drain_done) begin
      out_found_r <= found_r;
      out_tag_r   <= best_tag_r;
      out_dist_r  <= best_d_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_found             = out_found_r;
  assign out_match_x           = out_tag_r[3*W-1:2*W];
  assign out_match_y           = out_tag_r[2*W-1:W];
  assign out_match_z           = out_tag_r[W-1:0];
  assign out_match_index       = IDX_W'(out_tag_r[TAG_W-1:PW]);
  assign out_match_distance_sq = out_dist_r;

`ifndef NO_ASSERTIONS
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE)
    else $error("point store written outside idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MODEL_DEPTH))
    else $error("point count beyond store depth");

  a_dist_active: assert property (@(posedge clk) disable iff (!rst_n)
    dv |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("distance result outside a query");

  a_drain_out: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |=> out_valid_r)
    else $error("query finished without a result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_dist_r == '0)
    else $error("empty query result carries a distance");
`endif

endmodule

// File: tb/nearest_point_correspondence_tb.sv
`timescale 1ns / 1ps
module nearest_point_correspondence_tb;
  import npc_pkg::*;

  localparam int MODEL_DEPTH = 1024;
  localparam int CW = 16;
  localparam int RANDOM_ITEMS = 580;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = MODEL_DEPTH + 16;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} spread_t;

  typedef struct {
    logic                 found;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [IDX_W-1:0]     index;
    logic [DIST_W-1:0]    dist_sq;
  } match_t;

  typedef struct {
    logic [FUNC_W-1:0]    func;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    bit                   typed;
    match_t               want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [FUNC_W-1:0]    in_func = FUNC_LOAD;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic signed [CW-1:0] in_point_z = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_found;
  logic signed [CW-1:0] out_match_x;
  logic signed [CW-1:0] out_match_y;
  logic signed [CW-1:0] out_match_z;
  logic [IDX_W-1:0]     out_match_index;
  logic [DIST_W-1:0]    out_match_distance_sq;

  logic signed [CW-1:0] stored_x [MODEL_DEPTH];
  logic signed [CW-1:0] stored_y [MODEL_DEPTH];
  logic signed [CW-1:0] stored_z [MODEL_DEPTH];
  int                   stored_count = 0;
  match_t               pending_matches [$];
  stim_row_t            directed [$];
  int                   errors = 0;
  int                   idle_cycles = 0;
  bit                   calm = 1'b0;

  nearest_point_correspondence #(
    .MODEL_DEPTH(MODEL_DEPTH),
    .COORD_WIDTH(CW)
  ) dut (.*);

  always #6 clk = ~clk;

  function automatic stim_row_t stim_row(logic [FUNC_W-1:0] f, logic signed [CW-1:0] x,
                                         logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                                         bit typed = 1'b0, logic found = 1'b0,
                                         logic signed [CW-1:0] mx = '0,
                                         logic signed [CW-1:0] my = '0,
                                         logic signed [CW-1:0] mz = '0,
                                         logic [IDX_W-1:0] idx = '0,
                                         logic [DIST_W-1:0] dsq = '0);
    stim_row_t r;
    r.func = f;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.want.found = found;
    r.want.x = mx;
    r.want.y = my;
    r.want.z = mz;
    r.want.index = idx;
    r.want.dist_sq = dsq;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(spread_t s);
    logic [31:0] raw;
    raw = $urandom;
    case (s)
      SPREAD_NEAR: return CW'($signed($urandom_range(6)) - 3);
      SPREAD_EDGE: begin
        case ($urandom_range(4))
          0: return -32768;
          1: return -1;
          2: return 0;
          3: return 1;
          default: return 32767;
        endcase
      end
      default: return raw[CW-1:0];
    endcase
  endfunction

  function automatic stim_row_t query_row(spread_t s);
    int j;
    if (stored_count != 0 && $urandom_range(3) == 0) begin
      j = $urandom_range(stored_count - 1);
      return stim_row(FUNC_QUERY, stored_x[j], stored_y[j], stored_z[j]);
    end
    return stim_row(FUNC_QUERY, pick_coord(s), pick_coord(s), pick_coord(s));
  endfunction

  task automatic apply_request(input logic [FUNC_W-1:0] f, input logic signed [CW-1:0] x,
                               input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
                               output bit produces, output match_t m);
    longint dx, dy, dz, d;
    produces = 1'b0;
    m.found = 1'b0;
    m.x = '0;
    m.y = '0;
    m.z = '0;
    m.index = '0;
    m.dist_sq = '0;
    if (f == FUNC_LOAD) begin
      if (stored_count < MODEL_DEPTH) begin
        stored_x[stored_count] = x;
        stored_y[stored_count] = y;
        stored_z[stored_count] = z;
        stored_count++;
      end
    end else if (f == FUNC_CLEAR) begin
      stored_count = 0;
    end else if (f == FUNC_QUERY) begin
      produces = 1'b1;
      for (int i = 0; i < stored_count; i++) begin
        dx = longint'(stored_x[i]) - longint'(x);
        dy = longint'(stored_y[i]) - longint'(y);
        dz = longint'(stored_z[i]) - longint'(z);
        d = dx * dx + dy * dy + dz * dz;
        if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
        // keep the earliest point on a tie
        if (!m.found || d < longint'(m.dist_sq)) begin
          m.found = 1'b1;
          m.x = stored_x[i];
          m.y = stored_y[i];
          m.z = stored_z[i];
          m.index = IDX_W'(i);
          m.dist_sq = DIST_W'(d);
        end
      end
    end
  endtask

  task automatic send_request(stim_row_t r);
    bit     produces;
    match_t m;
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_valid   <= 1'b1;
    in_func    <= r.func;
    in_point_x <= r.x;
    in_point_y <= r.y;
    in_point_z <= r.z;
    do @(posedge clk); while (!in_ready);
    apply_request(r.func, r.x, r.y, r.z, produces, m);
    if (produces) begin
      if (r.typed) pending_matches.push_back(r.want);
      else pending_matches.push_back(m);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    match_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        $error("result with no request waiting, index %0d", out_match_index);
        errors++;
      end else begin
        w = pending_matches.pop_front();
        check_field("found", w.found, out_found);
        check_field("match_x", w.x, out_match_x);
        check_field("match_y", w.y, out_match_y);
        check_field("match_z", w.z, out_match_z);
        check_field("match_index", w.index, out_match_index);
        check_field("match_distance_sq", w.dist_sq, out_match_distance_sq);
      end
    end
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    out_ready <= calm || ($urandom_range(99) >= 17);
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $error("nothing moved for %0d cycles", IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int      issued;
    int      n;
    bit      filled;
    spread_t spread;
    logic [FUNC_W-1:0] f;

    directed.push_back(stim_row(FUNC_QUERY, 0, 0, 0, 1'b1));
    directed.push_back(stim_row(FUNC_QUERY, 32767, -32768, -1, 1'b1));
    directed.push_back(stim_row(FUNC_SPARE, 1, 2, 3));
    directed.push_back(stim_row(FUNC_QUERY, 5, 5, 5, 1'b1));
    directed.push_back(stim_row(FUNC_LOAD, -32768, -32768, -32768));
    directed.push_back(stim_row(FUNC_QUERY, 32767, 32767, 32767, 1'b1, 1'b1,
                                -32768, -32768, -32768, 0, 34'd12884508675));
    directed.push_back(stim_row(FUNC_QUERY, -32768, -32768, -32768, 1'b1, 1'b1,
                                -32768, -32768, -32768, 0, 0));
    directed.push_back(stim_row(FUNC_LOAD, 32767, 32767, 32767));
    directed.push_back(stim_row(FUNC_QUERY, 32767, 32767, 32767, 1'b1, 1'b1,
                                32767, 32767, 32767, 1, 0));
    directed.push_back(stim_row(FUNC_QUERY, 0, 0, 0));
    directed.push_back(stim_row(FUNC_LOAD, 100, 0, 0));
    directed.push_back(stim_row(FUNC_LOAD, -100, 0, 0));
    directed.push_back(stim_row(FUNC_LOAD, 100, 0, 0));
    directed.push_back(stim_row(FUNC_QUERY, 0, 0, 0));
    directed.push_back(stim_row(FUNC_QUERY, 100, 0, 0, 1'b1, 1'b1, 100, 0, 0, 2, 0));
    directed.push_back(stim_row(FUNC_LOAD, 0, 0, -1));
    directed.push_back(stim_row(FUNC_QUERY, 0, 0, 0));
    directed.push_back(stim_row(FUNC_CLEAR, 0, 0, 0));
    directed.push_back(stim_row(FUNC_QUERY, 1, 1, 1, 1'b1));
    directed.push_back(stim_row(FUNC_SPARE, -32768, 32767, 0));
    directed.push_back(stim_row(FUNC_LOAD, 1, -1, 1));
    directed.push_back(stim_row(FUNC_QUERY, -32768, 32767, -32768));
    directed.push_back(stim_row(FUNC_CLEAR, -1, -1, -1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i]);

    issued = 0;
    filled = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      calm = (issued >= 150 && issued < 250);
      spread = spread_t'($urandom_range(2));
      if (!filled && issued >= 400) begin
        // fill the store, overflow it, then query the far ends
        filled = 1'b1;
        send_request(stim_row(FUNC_CLEAR, pick_coord(SPREAD_FULL), 0, 0));
        repeat (MODEL_DEPTH + 4)
          send_request(stim_row(FUNC_LOAD, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL),
                                pick_coord(SPREAD_FULL)));
        send_request(stim_row(FUNC_QUERY, stored_x[MODEL_DEPTH-1], stored_y[MODEL_DEPTH-1],
                              stored_z[MODEL_DEPTH-1]));
        send_request(query_row(SPREAD_FULL));
        send_request(query_row(SPREAD_EDGE));
        send_request(stim_row(FUNC_CLEAR, 0, 0, 0));
        issued += 4;
      end else if ($urandom_range(99) < 80) begin
        if (stored_count > 48 || $urandom_range(2) != 0) begin
          send_request(stim_row(FUNC_CLEAR, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL),
                                pick_coord(SPREAD_FULL)));
          issued++;
        end
        n = $urandom_range(1, 12);
        repeat (n)
          send_request(stim_row(FUNC_LOAD, pick_coord(spread), pick_coord(spread),
                                pick_coord(spread)));
        issued += n;
        n = $urandom_range(1, 4);
        repeat (n) send_request(query_row(spread));
        issued += n;
      end else begin
        f = FUNC_W'($urandom_range(3));
        send_request(stim_row(f, pick_coord(spread), pick_coord(spread), pick_coord(spread)));
        if (f != FUNC_SPARE) issued++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
